// ===== rtl/core/gpga_pkg.sv =====
// ----------------------------------------------------------------------------
// gpga_pkg
// shared types, codes and saturating Q16.16 helpers for the gradient accumulator
// ----------------------------------------------------------------------------
package gpga_pkg;

    localparam int Q_W        = 32;
    localparam int KIND_W     = 3;
    localparam int ROW_W      = 1;
    localparam int COL_W      = 2;
    localparam int COL_IDX_W  = 4;
    localparam int MUL_W      = Q_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = KIND_W;
    localparam int M_TDATA_W  = Q_W;
    localparam int M_TUSER_W  = 1;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;
    localparam logic [Q_W-1:0] INV_VAR_RESET = 32'h0002_0000;

    localparam logic [KIND_W-1:0] KIND_LOAD_W = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_O = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACTION = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    typedef enum logic [1:0] {
        MUL_WO,
        MUL_EO,
        MUL_TI
    } mul_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ERR,
        RES_GRAD
    } res_sel_t;

    typedef struct packed {
        logic                 load_item;
        logic                 wr_weight;
        logic                 wr_obs;
        logic                 clr_grad;
        logic                 rd_en;
        logic [COL_IDX_W-1:0] rd_col;
        logic                 g_rd_en;
        logic                 g_rd_item;
        logic [COL_IDX_W-1:0] g_rd_col;
        logic                 mul_en;
        mul_sel_t             mul_sel;
        logic                 acc_add;
        logic                 err_set;
        logic                 g_wr;
        logic [COL_IDX_W-1:0] g_wr_col;
        logic                 out_load;
        res_sel_t             res_sel;
    } gpga_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              row_ok;
        logic              col_ok;
        logic              out_free;
    } gpga_stat_t;

    typedef struct packed {
        logic [Q_W-1:0] v;
        logic           sat;
    } q_res_t;

    // floor to Q16.16 then clamp to 32 bits
    function automatic q_res_t sat_floor16(input logic [PROD_W-1:0] p);
        logic [PROD_W-17:0] s;
        q_res_t             r;
        s     = p[PROD_W-1:16];
        r.sat = !((&s[PROD_W-17:Q_W-1]) || (~|s[PROD_W-17:Q_W-1]));
        r.v   = r.sat ? (s[PROD_W-17] ? Q_MIN : Q_MAX) : s[Q_W-1:0];
        return r;
    endfunction

    function automatic q_res_t add_sat(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b,
                                       input logic sub);
        logic [Q_W:0] s;
        q_res_t       r;
        s     = sub ? ({a[Q_W-1], a} - {b[Q_W-1], b}) : ({a[Q_W-1], a} + {b[Q_W-1], b});
        r.sat = s[Q_W] ^ s[Q_W-1];
        r.v   = r.sat ? (s[Q_W] ? Q_MIN : Q_MAX) : s[Q_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/gaussian_policy_grad_accum.sv =====
// ----------------------------------------------------------------------------
// gaussian_policy_grad_accum
// action item: result enters the output register after the dot and update passes
// load, clear and read items: result enters the output register after decode
// one item at a time; the next beat is taken once the result is in the output
// register; a stalled output holds the block in S_FIN until the register is free
// the shared multiplier sets the action time: one dot pass over the
// columns, then two products per column in the update pass
// rst_n async active low: gradient reads zero, inv_variance 2.0, no beat pending
// ----------------------------------------------------------------------------
module gaussian_policy_grad_accum
    import gpga_pkg::*;
#(
    parameter int ACTION_DIM = 2,
    parameter int POLICY_DIM = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // row, col, value, zero pad
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // kind
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // result_value
    output logic [M_TUSER_W-1:0] m_axis_tuser,  // saturated
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [Q_W-1:0]       cfg_data
);

    gpga_cmd_t  cmd;
    gpga_stat_t stat;
    logic       out_sat;

    assign cfg_ready = 1'b1;

    gpga_ctrl #(
        .POLICY_DIM (POLICY_DIM)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gpga_dp #(
        .ACTION_DIM (ACTION_DIM),
        .POLICY_DIM (POLICY_DIM)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_kind   (s_axis_tuser[KIND_W-1:0]),
        .in_row    (s_axis_tdata[ROW_W-1:0]),
        .in_col    (s_axis_tdata[ROW_W+COL_W-1:ROW_W]),
        .in_value  (s_axis_tdata[ROW_W+COL_W+Q_W-1:ROW_W+COL_W]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_sat   (out_sat)
    );

    assign m_axis_tuser = out_sat;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input beat taken while an item is in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten before its beat was taken");

    a_weight_port: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_weight || cmd.wr_obs || cmd.clr_grad) |-> (!cmd.rd_en && !cmd.mul_en && !cmd.g_wr))
        else $error("store update overlaps an action pass");
`endif

endmodule

// ===== rtl/core/gpga_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpga_ctrl
// sequencer: decodes each item and steps the dot and update passes
// ----------------------------------------------------------------------------
module gpga_ctrl
    import gpga_pkg::*;
#(
    parameter int POLICY_DIM = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  gpga_stat_t stat,
    output gpga_cmd_t  cmd
);

    localparam int CNT_W = $clog2(2 * POLICY_DIM + 2);
    localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO      = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE    = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_P        = CNT_W'(POLICY_DIM);
    localparam logic [CNT_W-1:0] CNT_2P       = CNT_W'(2 * POLICY_DIM);
    localparam logic [CNT_W-1:0] CNT_DOT_LAST = CNT_W'(POLICY_DIM + 1);
    localparam logic [CNT_W-1:0] CNT_UPD_LAST = CNT_W'(2 * POLICY_DIM + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DOT,
        S_UPD,
        S_FIN
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    res_sel_t         res_sel_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_WO;
        cmd.res_sel = res_sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = in_valid;
            end
            S_EXEC:
            begin
                unique case (stat.kind)
                    KIND_LOAD_W: cmd.wr_weight = stat.row_ok && stat.col_ok;
                    KIND_LOAD_O: cmd.wr_obs    = stat.col_ok;
                    KIND_CLEAR:  cmd.clr_grad  = 1'b1;
                    KIND_READ:
                    begin
                        cmd.g_rd_en   = stat.row_ok && stat.col_ok;
                        cmd.g_rd_item = 1'b1;
                    end
                    default:
                    begin
                        cmd.g_rd_item = 1'b0;
                    end
                endcase
            end
            S_DOT:
            begin
                cmd.rd_en   = (cnt_reg < CNT_P);
                cmd.rd_col  = COL_IDX_W'(cnt_reg);
                cmd.mul_en  = (cnt_reg >= CNT_ONE) && (cnt_reg <= CNT_P);
                cmd.acc_add = (cnt_reg >= CNT_TWO);
            end
            S_UPD:
            begin
                cmd.err_set  = (cnt_reg == '0);
                cmd.rd_en    = !cnt_reg[0] && (cnt_reg < CNT_2P);
                cmd.rd_col   = COL_IDX_W'(cnt_reg >> 1);
                cmd.mul_en   = (cnt_reg[0] && (cnt_reg < CNT_2P))
                               || (!cnt_reg[0] && (cnt_reg >= CNT_TWO));
                cmd.mul_sel  = cnt_reg[0] ? MUL_EO : MUL_TI;
                cmd.g_rd_en  = !cnt_reg[0] && (cnt_reg >= CNT_TWO);
                cmd.g_rd_col = COL_IDX_W'((cnt_reg >> 1) - CNT_ONE);
                cmd.g_wr     = cnt_reg[0] && (cnt_reg >= CNT_THREE);
                cmd.g_wr_col = COL_IDX_W'((cnt_reg >> 1) - CNT_ONE);
            end
            S_FIN:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd.load_item = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            res_sel_reg <= RES_ZERO;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    cnt_reg <= '0;
                    if (stat.kind == KIND_ACTION && stat.row_ok)
                    begin
                        res_sel_reg <= RES_ERR;
                        state_reg   <= S_DOT;
                    end
                    else
                    begin
                        res_sel_reg <= (stat.kind == KIND_READ && stat.row_ok && stat.col_ok)
                                       ? RES_GRAD : RES_ZERO;
                        state_reg   <= S_FIN;
                    end
                end
                S_DOT:
                begin
                    if (cnt_reg == CNT_DOT_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_ONE;
                    end
                end
                S_UPD:
                begin
                    if (cnt_reg == CNT_UPD_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_ONE;
                    end
                end
                S_FIN:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/gpga_dp.sv =====
// ----------------------------------------------------------------------------
// gpga_dp
// datapath: weight, observation and gradient stores, shared multiplier,
// accumulator and output register
// ----------------------------------------------------------------------------
module gpga_dp
    import gpga_pkg::*;
#(
    parameter int ACTION_DIM = 2,
    parameter int POLICY_DIM = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  gpga_cmd_t         cmd,
    output gpga_stat_t        stat,
    input  logic [KIND_W-1:0] in_kind,
    input  logic [ROW_W-1:0]  in_row,
    input  logic [COL_W-1:0]  in_col,
    input  logic [Q_W-1:0]    in_value,
    input  logic              cfg_valid,
    input  logic [Q_W-1:0]    cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [Q_W-1:0]    out_value,
    output logic              out_sat
);

    localparam int DEPTH = ACTION_DIM * POLICY_DIM;
    localparam int WA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OA    = (POLICY_DIM > 1) ? $clog2(POLICY_DIM) : 1;

    logic [KIND_W-1:0] kind_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [Q_W-1:0]    value_reg;

    logic [Q_W-1:0]    inv_var_reg;
    logic [Q_W-1:0]    w_mem [DEPTH];
    logic [Q_W-1:0]    o_mem [POLICY_DIM];
    logic [Q_W-1:0]    g_mem [DEPTH];
    logic [DEPTH-1:0]  g_valid_reg;

    logic [Q_W-1:0]    w_q_reg;
    logic [Q_W-1:0]    o_q_reg;
    logic [Q_W-1:0]    g_q_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [Q_W-1:0]    acc_reg;
    logic [Q_W-1:0]    err_reg;
    logic              sat_reg;
    logic              sat_next;
    logic              out_valid_reg;
    logic [Q_W-1:0]    out_value_reg;
    logic              out_sat_reg;

    logic [WA-1:0]     w_wr_addr;
    logic [WA-1:0]     w_rd_addr;
    logic [OA-1:0]     o_wr_addr;
    logic [OA-1:0]     o_rd_addr;
    logic [WA-1:0]     g_rd_addr;
    logic [WA-1:0]     g_wr_addr;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    q_res_t            prod_q;
    q_res_t            acc_sum;
    q_res_t            err_sum;
    q_res_t            g_new;
    logic [Q_W-1:0]    out_mux;

    assign w_wr_addr = WA'(32'(row_reg) * POLICY_DIM + 32'(col_reg));
    assign w_rd_addr = WA'(32'(row_reg) * POLICY_DIM + 32'(cmd.rd_col));
    assign o_wr_addr = OA'(col_reg);
    assign o_rd_addr = OA'(cmd.rd_col);
    assign g_rd_addr = cmd.g_rd_item ? w_wr_addr
                                     : WA'(32'(row_reg) * POLICY_DIM + 32'(cmd.g_rd_col));
    assign g_wr_addr = WA'(32'(row_reg) * POLICY_DIM + 32'(cmd.g_wr_col));

    assign stat.kind     = kind_reg;
    assign stat.row_ok   = (32'(row_reg) < ACTION_DIM);
    assign stat.col_ok   = (32'(col_reg) < POLICY_DIM);
    assign stat.out_free = !out_valid_reg || out_ready;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg  <= in_kind;
            row_reg   <= in_row;
            col_reg   <= in_col;
            value_reg <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_var_reg <= INV_VAR_RESET;
        end
        else if (cfg_valid)
        begin
            inv_var_reg <= cfg_data;
        end
    end

    // weight and observation stores
    always_ff @(posedge clk)
    begin
        if (cmd.wr_weight)
        begin
            w_mem[w_wr_addr] <= value_reg;
        end
        if (cmd.rd_en)
        begin
            w_q_reg <= w_mem[w_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_obs)
        begin
            o_mem[o_wr_addr] <= value_reg;
        end
        if (cmd.rd_en)
        begin
            o_q_reg <= o_mem[o_rd_addr];
        end
    end

    // gradient store, unwritten entries read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.g_wr)
        begin
            g_mem[g_wr_addr] <= g_new.v;
        end
        if (cmd.g_rd_en)
        begin
            g_q_reg <= g_valid_reg[g_rd_addr] ? g_mem[g_rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= '0;
        end
        else if (cmd.clr_grad)
        begin
            g_valid_reg <= '0;
        end
        else if (cmd.g_wr)
        begin
            g_valid_reg[g_wr_addr] <= 1'b1;
        end
    end

    // shared multiplier
    assign prod_q = sat_floor16(prod_reg);

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_WO:
            begin
                mul_a = {w_q_reg[Q_W-1], w_q_reg};
                mul_b = {o_q_reg[Q_W-1], o_q_reg};
            end
            MUL_EO:
            begin
                mul_a = {err_reg[Q_W-1], err_reg};
                mul_b = {o_q_reg[Q_W-1], o_q_reg};
            end
            MUL_TI:
            begin
                mul_a = {prod_q.v[Q_W-1], prod_q.v};
                mul_b = {1'b0, inv_var_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'($signed(mul_a) * $signed(mul_b));
        end
    end

    assign acc_sum = add_sat(acc_reg, prod_q.v, 1'b0);
    assign err_sum = add_sat(acc_reg, value_reg, 1'b1);
    assign g_new   = add_sat(g_q_reg, prod_q.v, 1'b1);

    always_comb
    begin
        sat_next = sat_reg
                   | (cmd.acc_add & (prod_q.sat | acc_sum.sat))
                   | (cmd.err_set & err_sum.sat)
                   | (cmd.mul_en & (cmd.mul_sel == MUL_TI) & prod_q.sat)
                   | (cmd.g_wr & (prod_q.sat | g_new.sat));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            sat_reg <= sat_next;
            if (cmd.acc_add)
            begin
                acc_reg <= acc_sum.v;
            end
        end
        if (cmd.err_set)
        begin
            err_reg <= err_sum.v;
        end
    end

    // result register
    always_comb
    begin
        unique case (cmd.res_sel)
            RES_ERR:  out_mux = err_reg;
            RES_GRAD: out_mux = g_q_reg;
            default:  out_mux = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg <= out_mux;
            out_sat_reg   <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_sat   = out_sat_reg;

endmodule

// ===== bench/gpga_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpga_checker
// Watches the item, result and inv_variance channels of the gradient
// accumulator. Keeps its own copy of the weights, observation, gradient and
// inv_variance, works out the result of every accepted item in saturating
// Q16.16, and compares each result beat against the oldest one outstanding.
// ----------------------------------------------------------------------------
module gpga_checker
    import gpga_pkg::*;
#(
    parameter int ACTION_DIM = 2,
    parameter int POLICY_DIM = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  logic [S_TDATA_W-1:0] item_data,   // row, col, value, zero pad
    input  logic [S_TUSER_W-1:0] item_user,   // kind
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  logic [M_TDATA_W-1:0] res_data,    // result_value
    input  logic [M_TUSER_W-1:0] res_user,    // saturated
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [Q_W-1:0]       cfg_data,
    output int                   outstanding,
    output int                   fail_cnt,
    output int                   n_items,
    output int                   n_actions,
    output int                   n_sat
);

    localparam logic signed [65:0] Q_HI66 = 66'sd2147483647;
    localparam logic signed [65:0] Q_LO66 = -66'sd2147483648;

    typedef struct packed {
        logic [Q_W-1:0] value;
        logic           sat;
    } grad_beat_t;

    logic signed [Q_W-1:0] weight_mem [ACTION_DIM*POLICY_DIM];
    logic signed [Q_W-1:0] obs_mem    [POLICY_DIM];
    logic signed [Q_W-1:0] grad_mem   [ACTION_DIM*POLICY_DIM];
    logic [Q_W-1:0]        inv_var;
    logic                  item_sat;
    grad_beat_t            pending_results [$];
    int                    beat_no;

    function automatic logic signed [Q_W-1:0] clip(input logic signed [65:0] x);
        if (x > Q_HI66)
        begin
            item_sat = 1'b1;
            return Q_MAX;
        end
        if (x < Q_LO66)
        begin
            item_sat = 1'b1;
            return Q_MIN;
        end
        return x[Q_W-1:0];
    endfunction

    function automatic logic signed [Q_W-1:0] clamp_sum(input logic signed [Q_W-1:0] a,
                                                        input logic signed [Q_W-1:0] b,
                                                        input logic minus);
        logic signed [65:0] x;
        logic signed [65:0] y;
        x = a;
        y = b;
        return clip(minus ? x - y : x + y);
    endfunction

    // exact product, floor to q16.16, clamp
    function automatic logic signed [Q_W-1:0] fixed_product(input logic signed [65:0] x,
                                                            input logic signed [65:0] y);
        logic signed [65:0] p;
        p = x * y;
        return clip(p >>> 16);
    endfunction

    task automatic predict_grad_item(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
                                     input logic [COL_W-1:0] col,
                                     input logic signed [Q_W-1:0] val);
        logic signed [Q_W-1:0] acc;
        logic signed [Q_W-1:0] err;
        logic signed [Q_W-1:0] t;
        logic signed [Q_W-1:0] u;
        logic signed [Q_W-1:0] res;
        logic signed [65:0]    wide_a;
        logic signed [65:0]    wide_b;
        logic                  row_ok;
        logic                  col_ok;
        grad_beat_t            e;
        int                    base;
        int                    c;
        res      = '0;
        item_sat = 1'b0;
        row_ok   = int'(row) < ACTION_DIM;
        col_ok   = int'(col) < POLICY_DIM;
        base     = int'(row) * POLICY_DIM;
        case (kind)
            KIND_LOAD_W:
                if (row_ok && col_ok)
                    weight_mem[base + int'(col)] = val;
            KIND_LOAD_O:
                if (col_ok)
                    obs_mem[int'(col)] = val;
            KIND_ACTION:
                if (row_ok)
                begin
                    acc = '0;
                    for (c = 0; c < POLICY_DIM; c++)
                    begin
                        wide_a = weight_mem[base + c];
                        wide_b = obs_mem[c];
                        acc = clamp_sum(acc, fixed_product(wide_a, wide_b), 1'b0);
                    end
                    err = clamp_sum(acc, val, 1'b1);
                    for (c = 0; c < POLICY_DIM; c++)
                    begin
                        wide_a = err;
                        wide_b = obs_mem[c];
                        t = fixed_product(wide_a, wide_b);
                        wide_a = t;
                        wide_b = {34'd0, inv_var};
                        u = fixed_product(wide_a, wide_b);
                        grad_mem[base + c] = clamp_sum(grad_mem[base + c], u, 1'b1);
                    end
                    res = err;
                end
            KIND_CLEAR:
                for (c = 0; c < ACTION_DIM * POLICY_DIM; c++)
                    grad_mem[c] = '0;
            KIND_READ:
                if (row_ok && col_ok)
                    res = grad_mem[base + int'(col)];
            default:
                ;
        endcase
        e.value = res;
        e.sat   = item_sat;
        pending_results.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input logic [Q_W-1:0] want,
                                   input logic [Q_W-1:0] got);
        $display("%0t: result beat %0d: %s expected %h got %h", $time, beat_no, what, want, got);
        fail_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grad_beat_t e;
        if (!rst_n)
        begin
            foreach (weight_mem[i])
            begin
                weight_mem[i] = '0;
                grad_mem[i]   = '0;
            end
            foreach (obs_mem[i])
                obs_mem[i] = '0;
            inv_var = INV_VAR_RESET;
            pending_results.delete();
            beat_no     = 0;
            fail_cnt    = 0;
            n_items     = 0;
            n_actions   = 0;
            n_sat       = 0;
            outstanding <= 0;
        end
        else
        begin
            // results first: a beat never belongs to an item taken at the same edge
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected beat, result_value", '0, res_data);
                else
                begin
                    e = pending_results.pop_front();
                    if (res_data !== e.value)
                        report_mismatch("result_value", e.value, res_data);
                    if (res_user !== e.sat)
                        report_mismatch("saturated", Q_W'(e.sat), Q_W'(res_user));
                    if (e.sat)
                        n_sat++;
                end
                beat_no++;
            end
            if (cfg_valid && cfg_ready)
                inv_var = cfg_data;
            if (item_valid && item_ready)
            begin
                if (item_user <= KIND_READ)
                    n_items++;
                if (item_user == KIND_ACTION)
                    n_actions++;
                predict_grad_item(item_user, item_data[0], item_data[2:1], item_data[34:3]);
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the gradient accumulator with a short directed run (every weight and
// observation set, some at extremes, actions, reads, clear, spare kinds, zero
// inv_variance) and then four random phases, each under its own inv_variance
// and idle/stall pattern. The checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module testbench;
    import gpga_pkg::*;

    localparam int ACTION_DIM  = 2;
    localparam int POLICY_DIM  = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 300;

    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // row, col, value, zero pad
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;   // kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // result_value
    logic [M_TUSER_W-1:0] m_axis_tuser;         // saturated
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [Q_W-1:0]       cfg_data      = '0;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_start     = 1'b0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;
    int   n_settings     = 1;

    int outstanding;
    int fail_cnt;
    int n_items;
    int n_actions;
    int n_sat;

    gaussian_policy_grad_accum #(
        .ACTION_DIM (ACTION_DIM),
        .POLICY_DIM (POLICY_DIM)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    gpga_checker #(
        .ACTION_DIM (ACTION_DIM),
        .POLICY_DIM (POLICY_DIM)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s_axis_tvalid),
        .item_ready  (s_axis_tready),
        .item_data   (s_axis_tdata),
        .item_user   (s_axis_tuser),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_data    (m_axis_tdata),
        .res_user    (m_axis_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .fail_cnt    (fail_cnt),
        .n_items     (n_items),
        .n_actions   (n_actions),
        .n_sat       (n_sat)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        m_axis_tready <= !hold_start && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, outstanding);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [Q_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, value, col, row};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_inv_variance(input logic [Q_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [Q_W-1:0] random_q();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return $urandom_range(32'h0006_0000) - 32'h0003_0000;
        if (pick < 85)
            return $urandom();
        case ($urandom_range(4))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return 32'h0000_0001;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    task automatic run_random(input int n_wanted, input int hold_at, input int pause_at);
        int                done;
        int                pick;
        logic [KIND_W-1:0] kind;
        done = 0;
        while (done < n_wanted)
        begin
            if (done == hold_at)
            begin
                // stall the output long enough for the block to back up its input
                s_axis_tvalid <= 1'b0;
                hold_start    <= 1'b1;
                @(posedge clk);
                hold_start    <= 1'b0;
                hold_at = -1;
            end
            if (done == pause_at)
            begin
                wait_drained();
                pause_at = -1;
            end
            pick = $urandom_range(99);
            if (pick < 28)
                kind = KIND_LOAD_W;
            else if (pick < 40)
                kind = KIND_LOAD_O;
            else if (pick < 75)
                kind = KIND_ACTION;
            else if (pick < 88)
                kind = KIND_READ;
            else if (pick < 91)
                kind = KIND_CLEAR;
            else
                kind = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
            send_item(kind, ROW_W'($urandom_range(1)), COL_W'($urandom_range(3)), random_q());
            if (kind <= KIND_READ)
                done++;
        end
    endtask

    initial
    begin
        logic [Q_W-1:0] phase_inv [4];
        int             phase_idle [4];
        int             phase_stall [4];
        int             ph;
        phase_inv   = '{32'h0000_0001, 32'hffff_ffff, 32'h0000_8000, 32'h0000_0000};
        phase_idle  = '{0, 75, 0, 6};
        phase_stall = '{0, 0, 75, 6};
        phase_inv[3] = $urandom_range(32'hffff_ffff, 1);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every weight and observation written before any action reads them
        send_item(KIND_LOAD_W, 1'b0, 2'd0, Q_MAX);
        send_item(KIND_LOAD_W, 1'b0, 2'd1, Q_MIN);
        send_item(KIND_LOAD_W, 1'b0, 2'd2, 32'h0001_0000);
        send_item(KIND_LOAD_W, 1'b0, 2'd3, 32'hffff_ffff);
        send_item(KIND_LOAD_W, 1'b1, 2'd0, 32'h0000_8000);
        send_item(KIND_LOAD_W, 1'b1, 2'd1, 32'hffff_0000);
        send_item(KIND_LOAD_W, 1'b1, 2'd2, 32'h0002_0000);
        send_item(KIND_LOAD_W, 1'b1, 2'd3, 32'h0000_0001);
        send_item(KIND_LOAD_O, 1'b0, 2'd0, 32'h0001_0000);
        send_item(KIND_LOAD_O, 1'b1, 2'd1, 32'hfffe_0000);
        send_item(KIND_LOAD_O, 1'b0, 2'd2, Q_MAX);
        send_item(KIND_LOAD_O, 1'b1, 2'd3, Q_MIN);
        send_item(KIND_ACTION, 1'b0, 2'd0, Q_MAX);
        send_item(KIND_ACTION, 1'b1, 2'd3, Q_MIN);
        send_item(KIND_ACTION, 1'b1, 2'd0, '0);
        send_item(KIND_READ, 1'b0, 2'd0, '0);
        send_item(KIND_READ, 1'b1, 2'd3, 32'hffff_ffff);
        send_item(KIND_SPARE_FIRST, 1'b1, 2'd3, 32'hffff_ffff);
        send_item(KIND_W'(KIND_SPARE_FIRST + 1), 1'b0, 2'd1, Q_MAX);
        send_item(KIND_SPARE_LAST, 1'b1, 2'd2, Q_MIN);
        send_item(KIND_CLEAR, 1'b0, 2'd0, '0);
        send_item(KIND_READ, 1'b1, 2'd1, '0);

        // zero inv_variance: the update adds nothing
        wait_drained();
        write_inv_variance('0);
        send_item(KIND_ACTION, 1'b0, 2'd2, 32'h0003_0000);
        send_item(KIND_READ, 1'b0, 2'd2, '0);

        for (ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            write_inv_variance(phase_inv[ph]);
            send_idle_pct   = phase_idle[ph];
            recv_stall_pct <= phase_stall[ph];
            run_random(PHASE_ITEMS, ph == 0 ? 120 : -1, ph == 2 ? 150 : -1);
        end

        recv_stall_pct <= 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items, %0d actions, %0d saturated results, %0d inv_variance settings",
                 n_items, n_actions, n_sat, n_settings);
        if (fail_cnt == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gpga_pkg.sv
rtl/core/gpga_ctrl.sv
rtl/core/gpga_dp.sv
rtl/core/gaussian_policy_grad_accum.sv
bench/gpga_checker.sv
bench/testbench.sv
